// File: hdl/bic_pkg.sv
// Shared types for the box intersection-over-union core.
package bic_pkg;

    typedef struct packed {
        logic valid;
        logic empty;
    } bic_tag_t;

endpackage

// File: hdl/bic_divider.sv
// Pipelined restoring divider that forms the overlap-over-union fraction.
module bic_divider #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 31,
    parameter int Q_W   = 17
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bic_pkg::bic_tag_t in_tag,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    output bic_pkg::bic_tag_t out_tag,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_quot,
    output logic [NUM_W-1:0]  out_num,
    output logic [DEN_W-1:0]  out_den
);
    import bic_pkg::*;

    localparam int LAST = Q_W - 1;

    logic             valid_reg [Q_W];
    logic             empty_reg [Q_W];
    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   quot_reg  [Q_W];
    logic [NUM_W-1:0] num_reg   [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    logic [Q_W:0]     stage_ready;

    assign stage_ready[Q_W] = out_ready;
    assign in_ready         = stage_ready[0];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             valid_in;
        logic             empty_in;
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   quot_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   quot_next;

        if (k == 0) begin : g_first
            assign valid_in = in_tag.valid;
            assign empty_in = in_tag.empty;
            assign rem_in   = {{(DEN_W - NUM_W){1'b0}}, in_num};
            assign quot_in  = '0;
            assign num_in   = in_num;
            assign den_in   = in_den;
            assign trial    = {1'b0, rem_in};
        end else begin : g_next
            assign valid_in = valid_reg[k-1];
            assign empty_in = empty_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign quot_in  = quot_reg[k-1];
            assign num_in   = num_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign trial    = {rem_in, 1'b0};
        end

        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        assign diff           = trial - {1'b0, den_in};
        assign take           = trial >= {1'b0, den_in};
        assign rem_next       = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign quot_next      = {quot_in[Q_W-2:0], take};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k]) begin
                empty_reg[k] <= empty_in;
                rem_reg[k]   <= rem_next;
                quot_reg[k]  <= quot_next;
                num_reg[k]   <= num_in;
                den_reg[k]   <= den_in;
            end
        end
    end

    assign out_tag.valid = valid_reg[LAST];
    assign out_tag.empty = empty_reg[LAST];
    assign out_quot      = empty_reg[LAST] ? '0 : quot_reg[LAST];
    assign out_num       = num_reg[LAST];
    assign out_den       = den_reg[LAST];

endmodule

// File: hdl/box_intersection_over_union_core.sv
// Top level of the streaming intersection-over-union core for two axis-aligned boxes.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | a_left, a_bottom, a_span_x/y, b_left, ...
//   m_      | out       | m_valid / m_ready  | iou_ratio, overlap_area, union_area, union_empty
//
// One box pair is accepted per cycle while m_ready does not stall the output, and each gives one result transaction.
// Stages: overlap lengths, three area multipliers, the union sum, then one restoring
// division step per stage for each quotient bit.
// Reset (aresetn, synchronous, active low) empties every stage; data registers are not reset.
// Each stage holds its data while the next is full, so a stall on m_ready fills
// empty stages before s_ready drops.
module box_intersection_over_union_core #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [COORD_BITS-1:0]     s_a_left,
    input  logic [COORD_BITS-1:0]     s_a_bottom,
    input  logic [COORD_BITS-2:0]     s_a_span_x,
    input  logic [COORD_BITS-2:0]     s_a_span_y,
    input  logic [COORD_BITS-1:0]     s_b_left,
    input  logic [COORD_BITS-1:0]     s_b_bottom,
    input  logic [COORD_BITS-2:0]     s_b_span_x,
    input  logic [COORD_BITS-2:0]     s_b_span_y,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FRACTION_BITS:0]    m_iou_ratio,
    output logic [2*COORD_BITS-3:0]   m_overlap_area,
    output logic [2*COORD_BITS-2:0]   m_union_area,
    output logic                      m_union_empty
);
    import bic_pkg::*;

    localparam int SPAN_W  = COORD_BITS - 1;
    localparam int DIFF_W  = COORD_BITS + 2;
    localparam int AREA_W  = 2 * SPAN_W;
    localparam int UNION_W = AREA_W + 1;
    localparam int RATIO_W = FRACTION_BITS + 1;
    localparam logic [RATIO_W-1:0] ONE_RATIO = {1'b1, {FRACTION_BITS{1'b0}}};

    function automatic logic [SPAN_W-1:0] overlap_len(
        input logic [COORD_BITS-1:0] lo_a,
        input logic [SPAN_W-1:0]     sp_a,
        input logic [COORD_BITS-1:0] lo_b,
        input logic [SPAN_W-1:0]     sp_b
    );
        logic signed [DIFF_W-1:0] la;
        logic signed [DIFF_W-1:0] lb;
        logic signed [DIFF_W-1:0] ha;
        logic signed [DIFF_W-1:0] hb;
        logic signed [DIFF_W-1:0] lo;
        logic signed [DIFF_W-1:0] hi;
        logic signed [DIFF_W-1:0] d;
        la = $signed({{2{lo_a[COORD_BITS-1]}}, lo_a});
        lb = $signed({{2{lo_b[COORD_BITS-1]}}, lo_b});
        ha = la + $signed({3'b000, sp_a});
        hb = lb + $signed({3'b000, sp_b});
        lo = (la > lb) ? la : lb;
        hi = (ha < hb) ? ha : hb;
        d  = hi - lo;
        return (!d[DIFF_W-1] && (d != '0)) ? d[SPAN_W-1:0] : '0;
    endfunction

    // Stage 1: overlap width and height.
    logic              s1_ready;
    logic              s1_valid_reg;
    logic [SPAN_W-1:0] s1_iw_reg;
    logic [SPAN_W-1:0] s1_ih_reg;
    logic [SPAN_W-1:0] s1_aw_reg;
    logic [SPAN_W-1:0] s1_ah_reg;
    logic [SPAN_W-1:0] s1_bw_reg;
    logic [SPAN_W-1:0] s1_bh_reg;
    logic [SPAN_W-1:0] s1_iw_next;
    logic [SPAN_W-1:0] s1_ih_next;

    // Stage 2: areas.
    logic              s2_ready;
    logic              s2_valid_reg;
    logic [AREA_W-1:0] s2_overlap_reg;
    logic [AREA_W-1:0] s2_area_a_reg;
    logic [AREA_W-1:0] s2_area_b_reg;

    // Stage 3: union.
    logic               s3_ready;
    logic               s3_valid_reg;
    logic               s3_empty_reg;
    logic [AREA_W-1:0]  s3_overlap_reg;
    logic [UNION_W-1:0] s3_union_reg;
    logic [UNION_W-1:0] s3_union_next;

    bic_tag_t           div_in_tag;
    logic               div_in_ready;
    bic_tag_t           div_out_tag;

    assign s1_iw_next = overlap_len(s_a_left, s_a_span_x, s_b_left, s_b_span_x);
    assign s1_ih_next = overlap_len(s_a_bottom, s_a_span_y, s_b_bottom, s_b_span_y);

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s3_ready = !s3_valid_reg || div_in_ready;
    assign s_ready  = s1_ready;

    assign s3_union_next = {1'b0, s2_area_a_reg} + {1'b0, s2_area_b_reg}
                         - {1'b0, s2_overlap_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_iw_reg <= s1_iw_next;
            s1_ih_reg <= s1_ih_next;
            s1_aw_reg <= s_a_span_x;
            s1_ah_reg <= s_a_span_y;
            s1_bw_reg <= s_b_span_x;
            s1_bh_reg <= s_b_span_y;
        end
        if (s2_ready) begin
            s2_overlap_reg <= {{SPAN_W{1'b0}}, s1_iw_reg} * {{SPAN_W{1'b0}}, s1_ih_reg};
            s2_area_a_reg  <= {{SPAN_W{1'b0}}, s1_aw_reg} * {{SPAN_W{1'b0}}, s1_ah_reg};
            s2_area_b_reg  <= {{SPAN_W{1'b0}}, s1_bw_reg} * {{SPAN_W{1'b0}}, s1_bh_reg};
        end
        if (s3_ready) begin
            s3_overlap_reg <= s2_overlap_reg;
            s3_union_reg   <= s3_union_next;
            s3_empty_reg   <= (s3_union_next == '0);
        end
    end

    assign div_in_tag.valid = s3_valid_reg;
    assign div_in_tag.empty = s3_empty_reg;

    bic_divider #(
        .NUM_W (AREA_W),
        .DEN_W (UNION_W),
        .Q_W   (RATIO_W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (div_in_tag),
        .in_ready  (div_in_ready),
        .in_num    (s3_overlap_reg),
        .in_den    (s3_union_reg),
        .out_tag   (div_out_tag),
        .out_ready (m_ready),
        .out_quot  (m_iou_ratio),
        .out_num   (m_overlap_area),
        .out_den   (m_union_area)
    );

    assign m_valid       = div_out_tag.valid;
    assign m_union_empty = div_out_tag.empty;

    a_empty_ratio_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_union_empty |-> m_iou_ratio == '0)
        else $error("Empty union did not give a zero ratio.");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_union_empty == (m_union_area == '0))
        else $error("Empty flag disagrees with the union area.");

    a_overlap_in_union: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_overlap_area} <= m_union_area)
        else $error("Overlap area exceeds union area.");

    a_ratio_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_union_empty |-> m_iou_ratio <= ONE_RATIO)
        else $error("Ratio exceeds one.");

    a_full_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_union_empty && ({1'b0, m_overlap_area} == m_union_area)
        |-> m_iou_ratio == ONE_RATIO)
        else $error("Full overlap did not give a ratio of one.");

endmodule
